>>> rtl/tcsm_pkg.sv
// Shared types and constants for the TCP connection state machine core.
// No dependencies; every other file in rtl/ imports this package.
package tcsm_pkg;

	localparam int unsigned StateW = 4;
	localparam int unsigned QueueDepthDefault = 4;

	// connection states
	localparam logic [StateW-1:0] ST_CLOSED      = 4'd0;
	localparam logic [StateW-1:0] ST_LISTEN      = 4'd1;
	localparam logic [StateW-1:0] ST_SYN_RECV    = 4'd2;
	localparam logic [StateW-1:0] ST_SYN_SENT    = 4'd3;
	localparam logic [StateW-1:0] ST_ESTABLISHED = 4'd4;
	localparam logic [StateW-1:0] ST_CLOSE_WAIT  = 4'd5;
	localparam logic [StateW-1:0] ST_LAST_ACK    = 4'd6;
	localparam logic [StateW-1:0] ST_FIN_WAIT_1  = 4'd7;
	localparam logic [StateW-1:0] ST_FIN_WAIT_2  = 4'd8;
	localparam logic [StateW-1:0] ST_CLOSING     = 4'd9;
	localparam logic [StateW-1:0] ST_TIME_WAIT   = 4'd10;

	// TCP flag bits
	localparam logic [7:0] FL_FIN = 8'h01;
	localparam logic [7:0] FL_SYN = 8'h02;
	localparam logic [7:0] FL_RST = 8'h04;
	localparam logic [7:0] FL_PSH = 8'h08;
	localparam logic [7:0] FL_ACK = 8'h10;

	// request commands
	localparam logic CMD_SEGMENT = 1'b0;
	localparam logic CMD_LOCAL   = 1'b1;

	// wake mask bits
	localparam logic [3:0] WAKE_CONNECT = 4'b0001;
	localparam logic [3:0] WAKE_ACCEPT  = 4'b0010;
	localparam logic [3:0] WAKE_RECV    = 4'b0100;
	localparam logic [3:0] WAKE_SEND    = 4'b1000;

	// child status codes
	localparam logic [1:0] CHILD_NONE   = 2'd0;
	localparam logic [1:0] CHILD_QUEUED = 2'd1;
	localparam logic [1:0] CHILD_FULL   = 2'd2;

	// close actions
	localparam logic [1:0] CLOSE_NONE     = 2'd0;
	localparam logic [1:0] CLOSE_RELEASE  = 2'd1;
	localparam logic [1:0] CLOSE_TIMEWAIT = 2'd2;

	typedef struct packed {
		logic              cmd;
		logic [StateW-1:0] forced_state;
		logic [7:0]        seg_flags;
		logic [31:0]       seq_num;
		logic [15:0]       payload_len;
		logic              accept_queue_full;
		logic              send_waiting;
	} item_t;

	typedef struct packed {
		logic [StateW-1:0] conn_state;
		logic [7:0]        send_flags;
		logic [3:0]        wake_mask;
		logic [15:0]       deliver_len;
		logic [31:0]       rcv_next;
		logic [1:0]        child_status;
		logic [31:0]       child_send_seq;
		logic [1:0]        close_action;
		logic              protocol_error;
	} result_t;

	// decoded request handed from front to back
	typedef struct packed {
		logic              is_local;
		logic              forced_ok;
		logic [StateW-1:0] forced_state;
		logic              fl_fin_ack;
		logic              fl_syn;
		logic              fl_syn_ack;
		logic              fl_ack;
		logic              fl_psh_ack;
		logic              fl_fin;
		logic              has_fin;
		logic              has_ack;
		logic [31:0]       seq_inc;
		logic [31:0]       seq_end;
		logic [15:0]       payload_len;
		logic              accept_queue_full;
		logic              send_waiting;
	} cls_t;

endpackage

>>> rtl/tcp_connection_state_machine_core.sv
// TCP connection receive state machine for one connection. Takes one request
// per clock while not stalled (a segment header or a local state change) and
// returns one result per request, in order, at a sustained rate of one per
// cycle while out_stall is low. A request passes through the front decode
// register, the request queue and the back end output register, where the
// state update happens. The back end's state update is what sets the rate.
// in_stall rises only when the request queue is full, which takes
// QueueDepth+1 requests held up behind a stalled output.
// initial_send_seq is written through cfg_we/cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce.
// Depends on tcsm_pkg, tcsm_front, tcsm_queue and tcsm_back.
module tcp_connection_state_machine_core #(
	parameter int unsigned QueueDepth = tcsm_pkg::QueueDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  tcsm_pkg::item_t   in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output tcsm_pkg::result_t out_result,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata
);
	import tcsm_pkg::*;

	logic push;
	logic q_ready;
	logic pop;
	logic q_valid;
	cls_t push_data;
	cls_t head;

	tcsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready)
	);

	tcsm_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.head      (head)
	);

	tcsm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_result (out_result)
	);

endmodule

>>> rtl/tcsm_front.sv
// Front end: accepts requests, decodes flag patterns and precomputes the
// sequence sums into one register stage. Depends on tcsm_pkg.
module tcsm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  tcsm_pkg::item_t in_item,
	output logic           push,
	output tcsm_pkg::cls_t push_data,
	input  logic           q_ready
);
	import tcsm_pkg::*;

	logic  s1_valid_s1;
	cls_t  cls_s1;
	cls_t  cls_d;

	always_comb begin
		cls_d.is_local          = (in_item.cmd == CMD_LOCAL);
		cls_d.forced_ok         = (in_item.forced_state <= ST_TIME_WAIT);
		cls_d.forced_state      = in_item.forced_state;
		cls_d.fl_fin_ack        = (in_item.seg_flags == (FL_FIN | FL_ACK));
		cls_d.fl_syn            = (in_item.seg_flags == FL_SYN);
		cls_d.fl_syn_ack        = (in_item.seg_flags == (FL_SYN | FL_ACK));
		cls_d.fl_ack            = (in_item.seg_flags == FL_ACK);
		cls_d.fl_psh_ack        = (in_item.seg_flags == (FL_PSH | FL_ACK));
		cls_d.fl_fin            = (in_item.seg_flags == FL_FIN);
		cls_d.has_fin           = |(in_item.seg_flags & FL_FIN);
		cls_d.has_ack           = |(in_item.seg_flags & FL_ACK);
		cls_d.seq_inc           = in_item.seq_num + 32'd1;
		cls_d.seq_end           = in_item.seq_num + {16'd0, in_item.payload_len};
		cls_d.payload_len       = in_item.payload_len;
		cls_d.accept_queue_full = in_item.accept_queue_full;
		cls_d.send_waiting      = in_item.send_waiting;
	end

	assign in_stall  = s1_valid_s1 && !q_ready;
	assign push      = s1_valid_s1 && q_ready;
	assign push_data = cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cls_s1 <= cls_d;
		end
	end

endmodule

>>> rtl/tcsm_queue.sv
// Short FIFO of decoded requests between front and back.
// Depends on tcsm_pkg for the entry type.
module tcsm_queue #(
	parameter int unsigned Depth = tcsm_pkg::QueueDepthDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcsm_pkg::cls_t push_data,
	output logic           q_ready,
	input  logic           pop,
	output logic           q_valid,
	output tcsm_pkg::cls_t head
);
	import tcsm_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	cls_t            entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign q_ready = (count_q != FullCnt);
	assign q_valid = (count_q != '0);
	assign head    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/tcsm_back.sv
// Back end: holds connection state and receive-next, applies one decoded
// request per unstalled cycle and registers the result. Depends on tcsm_pkg.
module tcsm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  tcsm_pkg::cls_t   head,
	output logic             pop,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	output logic             out_valid,
	input  logic             out_stall,
	output tcsm_pkg::result_t out_result
);
	import tcsm_pkg::*;

	logic [StateW-1:0] state_q;
	logic [31:0]       rcv_next_q;
	logic [31:0]       init_seq_q;
	logic              out_valid_q;
	result_t           result_q;

	logic [StateW-1:0] state_d;
	logic [31:0]       rcv_next_d;
	result_t           res_d;

	assign pop        = q_valid && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign out_result = result_q;

	always_comb begin
		state_d    = state_q;
		rcv_next_d = rcv_next_q;
		res_d      = '0;
		if (head.is_local) begin
			if (head.forced_ok) begin
				state_d = head.forced_state;
			end
		end else begin
			unique case (state_q)
				ST_CLOSED: begin
					res_d.protocol_error = !head.fl_fin_ack;
				end
				ST_LISTEN: begin
					if (head.fl_syn) begin
						// listener stays put; result describes the child
						res_d.child_status   = head.accept_queue_full ? CHILD_FULL
						                                              : CHILD_QUEUED;
						res_d.child_send_seq = init_seq_q;
						res_d.send_flags     = FL_SYN | FL_ACK;
					end else begin
						res_d.protocol_error = !head.fl_fin_ack;
					end
				end
				ST_SYN_SENT: begin
					if (head.fl_syn_ack) begin
						rcv_next_d      = head.seq_inc;
						res_d.wake_mask = WAKE_CONNECT;
					end else if (head.fl_syn) begin
						state_d          = ST_SYN_RECV;
						res_d.send_flags = FL_SYN | FL_ACK;
					end else begin
						res_d.protocol_error = 1'b1;
					end
				end
				ST_SYN_RECV: begin
					if (head.fl_ack) begin
						state_d         = ST_ESTABLISHED;
						res_d.wake_mask = WAKE_ACCEPT;
					end else begin
						res_d.protocol_error = 1'b1;
					end
				end
				ST_ESTABLISHED: begin
					if (head.has_fin) begin
						state_d          = ST_CLOSE_WAIT;
						res_d.send_flags = FL_ACK;
						res_d.wake_mask  = WAKE_RECV | WAKE_SEND;
					end else if (head.fl_psh_ack) begin
						res_d.deliver_len = head.payload_len;
						rcv_next_d        = head.seq_end;
						res_d.send_flags  = FL_ACK;
						res_d.wake_mask   = WAKE_RECV;
					end else if (head.fl_ack) begin
						res_d.wake_mask = head.send_waiting ? WAKE_SEND : 4'd0;
					end else begin
						res_d.protocol_error = 1'b1;
					end
				end
				ST_FIN_WAIT_1: begin
					if (head.has_ack) begin
						state_d = ST_FIN_WAIT_2;
					end else if (head.fl_fin) begin
						state_d          = ST_CLOSING;
						res_d.send_flags = FL_ACK;
					end else begin
						res_d.protocol_error = 1'b1;
					end
				end
				ST_FIN_WAIT_2: begin
					// time-wait folded: straight to CLOSED, timer left to caller
					if (head.has_fin) begin
						state_d            = ST_CLOSED;
						res_d.send_flags   = FL_ACK;
						res_d.close_action = CLOSE_TIMEWAIT;
					end else begin
						res_d.protocol_error = 1'b1;
					end
				end
				ST_CLOSING: begin
					if (head.fl_ack) begin
						state_d = ST_TIME_WAIT;
					end else begin
						res_d.protocol_error = 1'b1;
					end
				end
				ST_CLOSE_WAIT: begin
					res_d.protocol_error = !(head.has_fin || head.has_ack);
				end
				ST_LAST_ACK: begin
					if (head.has_ack) begin
						state_d            = ST_CLOSED;
						res_d.close_action = CLOSE_RELEASE;
					end else begin
						res_d.protocol_error = 1'b1;
					end
				end
				default: begin
					res_d.protocol_error = 1'b1;
				end
			endcase
		end
		res_d.conn_state = state_d;
		res_d.rcv_next   = (res_d.child_status != CHILD_NONE) ? head.seq_inc : rcv_next_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLOSED;
			rcv_next_q  <= '0;
			init_seq_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				init_seq_q <= cfg_wdata;
			end
			if (pop) begin
				state_q     <= state_d;
				rcv_next_q  <= rcv_next_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_d;
		end
	end

endmodule

>>> rtl/tcsm_checker.sv
// Port-level checks for the TCP connection state machine core, plus the bind
// that attaches them to the top level. Depends on tcsm_pkg.
module tcsm_assertions (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input tcsm_pkg::result_t out_result
);
	import tcsm_pkg::*;

	// held result must not move while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_result))
		else $error("result changed while stalled");

	// an error result carries no actions
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_result.protocol_error |->
			out_result.send_flags == 8'd0 && out_result.wake_mask == 4'd0 &&
			out_result.child_status == CHILD_NONE &&
			out_result.close_action == CLOSE_NONE && out_result.deliver_len == 16'd0)
		else $error("error result with side effects");

	// a spawned child only comes from a listener answering with SYN+ACK
	a_child_listen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_result.child_status != CHILD_NONE |->
			out_result.conn_state == ST_LISTEN &&
			out_result.send_flags == (FL_SYN | FL_ACK))
		else $error("child spawned outside LISTEN");

	// any release leaves the connection closed
	a_close_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_result.close_action != CLOSE_NONE |->
			out_result.conn_state == ST_CLOSED)
		else $error("release without CLOSED state");

	// payload is delivered only on an established connection
	a_deliver_est: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_result.deliver_len != 16'd0 |->
			out_result.conn_state == ST_ESTABLISHED)
		else $error("payload delivered outside ESTABLISHED");

endmodule

bind tcp_connection_state_machine_core tcsm_assertions u_tcsm_assertions (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_result (out_result)
);
